[design/srl_pkg.sv]
// Package: shared types and constants for the S-record stream loader.
`default_nettype none
package srl_pkg;

   // Parse phases
   localparam logic [2:0] PH_LEAD  = 3'd0;
   localparam logic [2:0] PH_TYPE  = 3'd1;
   localparam logic [2:0] PH_COUNT = 3'd2;
   localparam logic [2:0] PH_AHI   = 3'd3;
   localparam logic [2:0] PH_ALO   = 3'd4;
   localparam logic [2:0] PH_DATA  = 3'd5;
   localparam logic [2:0] PH_CHECK = 3'd6;
   localparam logic [2:0] PH_DONE  = 3'd7;

   // Result kinds
   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_START  = 2'd1;
   localparam logic [1:0] KIND_FORMAT = 2'd2;
   localparam logic [1:0] KIND_CHKSUM = 2'd3;

   // Characters
   localparam logic [7:0] CHAR_S      = 8'h53;
   localparam logic [7:0] CHAR_ONE    = 8'h31;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;

   localparam logic [7:0]  SUM_GOOD  = 8'hFF;
   localparam logic [7:0]  MIN_COUNT = 8'd3;
   localparam logic [15:0] LINE_MAX  = 16'hFFFF;

   typedef struct packed {
      logic [7:0] ch;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] address;
      logic [7:0]  data_byte;
      logic [15:0] line_number;
   } rsp_type;

   // One parser step: whether it yields a result, and the result
   typedef struct packed {
      logic    emit;
      rsp_type result;
   } step_type;

   typedef struct packed {
      logic       halted;
   } status_type;

endpackage
`default_nettype wire

[design/srl_stream_if.sv]
// Interfaces: valid/ready request and response channels.
`default_nettype none
interface srl_req_if import srl_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface srl_rsp_if import srl_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[design/srl_hex_decode.sv]
// Hex digit decoder: ASCII character to nibble plus a digit flag.
`default_nettype none
module srl_hex_decode import srl_pkg::*; (
   input  wire logic [7:0] ch,
   output logic [3:0]      nibble,
   output logic            is_hex
);
   always_comb begin
      nibble = 4'd0;
      is_hex = 1'b0;
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         nibble = 4'(ch - CHAR_ZERO);
         is_hex = 1'b1;
      end else if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_F) begin
         nibble = 4'(ch - CHAR_UPPER_A + 8'd10);
         is_hex = 1'b1;
      end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_F) begin
         nibble = 4'(ch - CHAR_LOWER_A + 8'd10);
         is_hex = 1'b1;
      end
   end
endmodule
`default_nettype wire

[design/srl_parser.sv]
// Record parser: parse state registers and the per-character update.
`default_nettype none
module srl_parser import srl_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step_en,
   input  wire req_type item,
   output step_type     step,
   output status_type   status
);
   logic [2:0]  phase_ff,   phase_in;
   logic        pending_ff, pending_in;
   logic [3:0]  high_ff,    high_in;
   logic        rtype_ff,   rtype_in;
   logic        type_ok_ff, type_ok_in;
   logic [7:0]  left_ff,    left_in;
   logic [16:0] addr_ff,    addr_in;
   logic [7:0]  sum_ff,     sum_in;
   logic [15:0] line_ff,    line_in;
   logic        halted_ff,  halted_in;

   logic [3:0] nibble;
   logic       is_hex;
   logic [7:0] byte_val;
   logic [7:0] sum_next;

   srl_hex_decode u_hex (
      .ch     (item.ch),
      .nibble (nibble),
      .is_hex (is_hex)
   );

   assign byte_val = {high_ff, nibble};
   assign sum_next = sum_ff + byte_val;

   always_comb begin
      phase_in   = phase_ff;
      pending_in = pending_ff;
      high_in    = high_ff;
      rtype_in   = rtype_ff;
      type_ok_in = type_ok_ff;
      left_in    = left_ff;
      addr_in    = addr_ff;
      sum_in     = sum_ff;
      line_in    = line_ff;
      halted_in  = halted_ff;
      step.emit               = 1'b0;
      step.result.kind        = KIND_FORMAT;
      step.result.address     = 16'd0;
      step.result.data_byte   = 8'd0;
      step.result.line_number = line_ff;

      if (!halted_ff) begin
         if (item.line_end) begin
            if (phase_ff != PH_DONE) begin
               step.emit = 1'b1;
               halted_in = 1'b1;
            end else begin
               if (line_ff != LINE_MAX) begin
                  line_in = line_ff + 16'd1;
               end
               phase_in   = PH_LEAD;
               pending_in = 1'b0;
            end
         end else if (phase_ff == PH_DONE) begin
            // trailing text ignored
         end else if (phase_ff == PH_LEAD) begin
            if (item.ch != CHAR_S) begin
               step.emit = 1'b1;
               halted_in = 1'b1;
            end else begin
               phase_in = PH_TYPE;
            end
         end else if (phase_ff == PH_TYPE) begin
            rtype_in   = (item.ch == CHAR_NINE);
            type_ok_in = (item.ch == CHAR_ONE) || (item.ch == CHAR_NINE);
            sum_in     = 8'd0;
            pending_in = 1'b0;
            phase_in   = PH_COUNT;
         end else if ((phase_ff == PH_DATA && !pending_ff && addr_ff[16]) || !is_hex) begin
            // address overflow or bad digit
            step.emit = 1'b1;
            halted_in = 1'b1;
         end else if (!pending_ff) begin
            high_in    = nibble;
            pending_in = 1'b1;
         end else begin
            pending_in = 1'b0;
            sum_in     = sum_next;
            case (phase_ff)
               PH_COUNT: begin
                  if (byte_val < MIN_COUNT) begin
                     step.emit = 1'b1;
                     halted_in = 1'b1;
                  end else begin
                     left_in  = byte_val - MIN_COUNT;
                     phase_in = PH_AHI;
                  end
               end
               PH_AHI: begin
                  addr_in  = {1'b0, byte_val, 8'd0};
                  phase_in = PH_ALO;
               end
               PH_ALO: begin
                  addr_in = {addr_ff[16:8], byte_val};
                  if (!type_ok_ff || (rtype_ff && left_ff != 8'd0)) begin
                     step.emit = 1'b1;
                     halted_in = 1'b1;
                  end else begin
                     phase_in = (left_ff != 8'd0) ? PH_DATA : PH_CHECK;
                  end
               end
               PH_DATA: begin
                  step.emit             = 1'b1;
                  step.result.kind      = KIND_WRITE;
                  step.result.address   = addr_ff[15:0];
                  step.result.data_byte = byte_val;
                  addr_in = addr_ff + 17'd1;
                  left_in = left_ff - 8'd1;
                  if (left_ff == 8'd1) begin
                     phase_in = PH_CHECK;
                  end
               end
               default: begin
                  phase_in = PH_DONE;
                  if (sum_next != SUM_GOOD) begin
                     step.emit        = 1'b1;
                     step.result.kind = KIND_CHKSUM;
                     halted_in        = 1'b1;
                  end else if (rtype_ff) begin
                     step.emit           = 1'b1;
                     step.result.kind    = KIND_START;
                     step.result.address = addr_ff[15:0];
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LEAD;
         pending_ff <= 1'b0;
         high_ff    <= 4'd0;
         rtype_ff   <= 1'b0;
         type_ok_ff <= 1'b0;
         left_ff    <= 8'd0;
         addr_ff    <= 17'd0;
         sum_ff     <= 8'd0;
         line_ff    <= 16'd1;
         halted_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
         high_ff    <= high_in;
         rtype_ff   <= rtype_in;
         type_ok_ff <= type_ok_in;
         left_ff    <= left_in;
         addr_ff    <= addr_in;
         sum_ff     <= sum_in;
         line_ff    <= line_in;
         halted_ff  <= halted_in;
      end
   end

   assign status.halted = halted_ff;
endmodule
`default_nettype wire

[design/srecord_stream_loader_unit.sv]
// A request is held in the input register, and its response (if any) in the response register.
// Throughput: one request per cycle; a stall on the response side holds the input register.
// Timing path: input register -> hex decode / parse update -> response register.
// Reset (synchronous, active high): parser to lead 'S', line 1, not halted; both
// register stages empty. After any error response the unit drops all requests.
`default_nettype none
module srecord_stream_loader_unit import srl_pkg::*; (
   input wire logic  clock,
   input wire logic  reset,
   srl_req_if.sink   req_chan,
   srl_rsp_if.source rsp_chan
);
   // Input register stage
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;

   // Response register stage
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;

   step_type   step;
   status_type status;
   logic       step_en;

   // The parser advances when an input item is held and the response slot
   // is free or being drained this cycle. Every step commits, even one that
   // yields no response.
   assign step_en = in_valid_ff && (!out_valid_ff || rsp_chan.ready);

   // Input register reloads whenever it is empty or its item is consumed.
   assign req_chan.ready = !in_valid_ff || step_en;

   assign in_valid_in  = req_chan.valid ? 1'b1 : (in_valid_ff && !step_en);
   assign out_valid_in = step_en ? step.emit : (out_valid_ff && !rsp_chan.ready);

   srl_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_data_ff),
      .step    (step),
      .status  (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= in_valid_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_data_ff <= req_chan.payload;
      end
      if (step_en) begin
         out_data_ff <= step.result;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

`ifndef SYNTHESIS
   // An error response always leaves the parser halted.
   a_error_halts : assert property (@(posedge clock) disable iff (reset)
      step_en && step.emit &&
      (step.result.kind == KIND_FORMAT || step.result.kind == KIND_CHKSUM)
      |=> status.halted)
      else $error("error response did not halt the parser");

   // Once halted, no step yields a response.
   a_halted_silent : assert property (@(posedge clock) disable iff (reset)
      status.halted && step_en |-> !step.emit)
      else $error("response produced while halted");

   // Error responses carry zero address and data.
   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff &&
      (out_data_ff.kind == KIND_FORMAT || out_data_ff.kind == KIND_CHKSUM)
      |-> out_data_ff.address == 16'd0 && out_data_ff.data_byte == 8'd0)
      else $error("error response with nonzero address or data");
`endif
endmodule
`default_nettype wire

[sim/srecord_stream_loader_unit_tb.sv]
// Testbench for the S-record stream loader: S1/S9 records checked against a parser model.
module srecord_stream_loader_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import srl_pkg::*;

   // Random part length, in requests
   localparam int RANDOM_REQUESTS = 200;
   // Data bytes in the record streamed during the receiver hold-off
   localparam int HOLD_BYTES      = 32;
   // Receiver hold-off used to fill the pipeline and stall the input
   localparam int HOLD_CYCLES     = 300;
   // Cycles with no transfer on either channel before the run is called hung
   localparam int WATCHDOG_LIMIT  = 2000;
   // Edges waited as margin after the last owed output is taken
   localparam int LATENCY_SLACK   = 8;

   // Ways to break the closing record. An error halts the block until reset,
   // and reset is applied once, so exactly one of these ends each run.
   typedef enum int {
      BREAK_LEAD,
      BREAK_EMPTY,
      BREAK_TYPE,
      BREAK_SHORT_COUNT,
      BREAK_S9_DATA,
      BREAK_BAD_DIGIT,
      BREAK_MISSING_DIGIT,
      BREAK_OVERFLOW,
      BREAK_CHECKSUM
   } break_kind_type;

   logic clock;
   logic reset;

   srl_req_if req_chan ();
   srl_rsp_if rsp_chan ();

   srecord_stream_loader_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // ---------------------------------------------------------------------
   // Parser model state (mirrors the block's architectural state)
   // ---------------------------------------------------------------------
   logic [2:0]  prs_phase;
   logic        prs_nib_pend;
   logic [3:0]  prs_high;
   logic        prs_is_s9;
   logic        prs_type_ok;
   logic [7:0]  prs_left;
   logic [16:0] prs_addr;      // one extra bit to catch running past 0xFFFF
   logic [7:0]  prs_sum;
   logic [15:0] prs_line;
   logic        prs_halted;

   rsp_type     predicted_outputs[$];   // loader outputs still owed by the block
   req_type     line_text[$];           // characters of the line being built

   logic        sender_gaps;
   logic        receiver_stalls;
   logic        hold_request;
   int          stall_left;
   int          quiet_cycles;
   int          req_total;
   int          rsp_total;
   int          write_total;
   int          start_total;
   int          mismatches;
   break_kind_type closing_break;

   // ---------------------------------------------------------------------
   // Clock and watchdog
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Any transfer on either side counts as progress. The long hold-off is
   // well under the limit, so only a hung block or a lost response trips it.
   initial quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TIMEOUT after %0d idle cycles, %0d outputs still owed",
                  quiet_cycles, predicted_outputs.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Parser model
   // ---------------------------------------------------------------------
   function automatic void reset_parser();
      prs_phase    = PH_LEAD;
      prs_nib_pend = 1'b0;
      prs_high     = 4'h0;
      prs_is_s9    = 1'b0;
      prs_type_ok  = 1'b0;
      prs_left     = 8'h00;
      prs_addr     = 17'h0;
      prs_sum      = 8'h00;
      prs_line     = 16'd1;
      prs_halted   = 1'b0;
   endfunction

   // Value of a hex digit in either case, -1 for anything else
   function automatic int hex_value(logic [7:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) return int'(c - CHAR_UPPER_A) + 10;
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) return int'(c - CHAR_LOWER_A) + 10;
      return -1;
   endfunction

   // Every error reports once, with address and data zeroed, then halts
   function automatic step_type loader_fault(logic [1:0] kind);
      step_type s;
      prs_halted = 1'b1;
      s.emit     = 1'b1;
      s.result   = '{kind: kind, address: 16'h0000, data_byte: 8'h00, line_number: prs_line};
      return s;
   endfunction

   // Advance the model by one request; returns the output it owes, if any
   function automatic step_type parse_char(req_type r);
      step_type s;
      int       v;
      logic [7:0] b;
      s = '0;
      if (prs_halted) return s;

      // End of line: only legal once the checksum byte is in
      if (r.line_end) begin
         if (prs_phase != PH_DONE) return loader_fault(KIND_FORMAT);
         if (prs_line != LINE_MAX) prs_line = prs_line + 16'd1;
         prs_phase    = PH_LEAD;
         prs_nib_pend = 1'b0;
         return s;
      end

      if (prs_phase == PH_DONE) return s;   // trailing text
      if (prs_phase == PH_LEAD) begin
         if (r.ch != CHAR_S) return loader_fault(KIND_FORMAT);
         prs_phase = PH_TYPE;
         return s;
      end
      if (prs_phase == PH_TYPE) begin
         // any type is taken here; a bad one is flagged once the address is in
         prs_is_s9    = (r.ch == CHAR_NINE);
         prs_type_ok  = (r.ch == CHAR_ONE) || (r.ch == CHAR_NINE);
         prs_sum      = 8'h00;
         prs_nib_pend = 1'b0;
         prs_phase    = PH_COUNT;
         return s;
      end

      // Overflow is caught on the first digit of a data byte, ahead of the digit check
      if (prs_phase == PH_DATA && !prs_nib_pend && prs_addr[16]) begin
         return loader_fault(KIND_FORMAT);
      end
      v = hex_value(r.ch);
      if (v < 0) return loader_fault(KIND_FORMAT);
      if (!prs_nib_pend) begin
         prs_high     = v[3:0];
         prs_nib_pend = 1'b1;
         return s;
      end
      prs_nib_pend = 1'b0;
      b            = {prs_high, v[3:0]};
      prs_sum      = prs_sum + b;

      case (prs_phase)
         PH_COUNT: begin
            if (b < MIN_COUNT) return loader_fault(KIND_FORMAT);
            prs_left  = b - MIN_COUNT;
            prs_phase = PH_AHI;
         end
         PH_AHI: begin
            prs_addr  = {1'b0, b, 8'h00};
            prs_phase = PH_ALO;
         end
         PH_ALO: begin
            prs_addr[7:0] = b;
            if (!prs_type_ok) return loader_fault(KIND_FORMAT);
            if (prs_is_s9 && prs_left != 8'h00) return loader_fault(KIND_FORMAT);
            prs_phase = (prs_left != 8'h00) ? PH_DATA : PH_CHECK;
         end
         PH_DATA: begin
            s.emit   = 1'b1;
            s.result = '{kind: KIND_WRITE, address: prs_addr[15:0], data_byte: b,
                         line_number: prs_line};
            prs_addr = prs_addr + 17'd1;
            prs_left = prs_left - 8'd1;
            if (prs_left == 8'h00) prs_phase = PH_CHECK;
         end
         default: begin
            // checksum byte
            prs_phase = PH_DONE;
            if (prs_sum != SUM_GOOD) return loader_fault(KIND_CHKSUM);
            if (prs_is_s9) begin
               s.emit   = 1'b1;
               s.result = '{kind: KIND_START, address: prs_addr[15:0], data_byte: 8'h00,
                            line_number: prs_line};
            end
         end
      endcase
      return s;
   endfunction

   // ---------------------------------------------------------------------
   // Response side: ready driver and checker
   // ---------------------------------------------------------------------
   task automatic report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // One nonblocking write to ready per edge. A hold request turns into a
   // long run of low-ready cycles counted here, independent of the sender.
   initial begin
      rsp_chan.ready <= 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (hold_request) begin
            hold_request   = 1'b0;
            stall_left     = HOLD_CYCLES - 1;
            rsp_chan.ready <= 1'b0;
         end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
            stall_left     = $urandom_range(0, 8);   // burst of low ready, of random length
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   rsp_type want;
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         rsp_total++;
         if (predicted_outputs.size() == 0) begin
            report_mismatch($sformatf("unexpected output kind %0d addr %h data %h line %0d",
                                      rsp_chan.payload.kind, rsp_chan.payload.address,
                                      rsp_chan.payload.data_byte,
                                      rsp_chan.payload.line_number));
         end else begin
            want = predicted_outputs.pop_front();
            if (want.kind == KIND_WRITE) write_total++;
            if (want.kind == KIND_START) start_total++;
            if (rsp_chan.payload.kind !== want.kind)
               report_mismatch($sformatf("kind got %0d want %0d",
                                         rsp_chan.payload.kind, want.kind));
            if (rsp_chan.payload.address !== want.address)
               report_mismatch($sformatf("address got %h want %h",
                                         rsp_chan.payload.address, want.address));
            if (rsp_chan.payload.data_byte !== want.data_byte)
               report_mismatch($sformatf("data_byte got %h want %h",
                                         rsp_chan.payload.data_byte, want.data_byte));
            if (rsp_chan.payload.line_number !== want.line_number)
               report_mismatch($sformatf("line_number got %0d want %0d",
                                         rsp_chan.payload.line_number, want.line_number));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Offer one request and hold it until taken; the model steps at the
   // accepting edge. Valid stays high between back-to-back requests.
   task automatic send_request(req_type r);
      step_type s;
      if (sender_gaps && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= r;
      do @(posedge clock); while (!req_chan.ready);
      req_total++;
      s = parse_char(r);
      if (s.emit) predicted_outputs.push_back(s.result);
   endtask

   function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
      if (n < 4'd10) return CHAR_ZERO + 8'(n);
      return (lower ? CHAR_LOWER_A : CHAR_UPPER_A) + 8'(n) - 8'd10;
   endfunction

   function automatic void push_char(logic [7:0] c);
      line_text.push_back('{ch: c, line_end: 1'b0});
   endfunction

   function automatic void push_byte(logic [7:0] b, bit mix_case);
      push_char(hex_char(b[7:4], mix_case && ($urandom_range(0, 1) == 1)));
      push_char(hex_char(b[3:0], mix_case && ($urandom_range(0, 1) == 1)));
   endfunction

   // Lay out one record in line_text. The checksum is made good, then
   // skewed by sum_skew; a count_override of -1 keeps the natural count.
   task automatic build_record(input logic [7:0] type_ch, input logic [15:0] addr,
                               input logic [7:0] bytes[$], input logic [7:0] sum_skew,
                               input bit mix_case, input int count_override);
      logic [7:0] count;
      logic [7:0] sum;
      count = (count_override < 0) ? 8'(bytes.size() + 3) : 8'(count_override);
      line_text.delete();
      push_char(CHAR_S);
      push_char(type_ch);
      sum = count + addr[15:8] + addr[7:0];
      push_byte(count, mix_case);
      push_byte(addr[15:8], mix_case);
      push_byte(addr[7:0], mix_case);
      foreach (bytes[i]) begin
         push_byte(bytes[i], mix_case);
         sum += bytes[i];
      end
      push_byte(SUM_GOOD - sum + sum_skew, mix_case);
   endtask

   // Send line_text, then any trailing junk, then the end-of-line mark
   // (its character is random; the block must ignore it).
   task automatic send_line(int n_trail, bit with_eol);
      foreach (line_text[i]) send_request(line_text[i]);
      repeat (n_trail) send_request('{ch: 8'($urandom_range(0, 255)), line_end: 1'b0});
      if (with_eol) send_request('{ch: 8'($urandom_range(0, 255)), line_end: 1'b1});
   endtask

   // Well-formed record with random content: mostly S1 with short data,
   // sometimes longer, sometimes ending right at 0xFFFF, some S9.
   task automatic send_random_record();
      logic [7:0]  bytes[$];
      logic [15:0] addr;
      int          n;
      bit          is_s9;
      is_s9 = ($urandom_range(0, 7) == 0);
      if (is_s9) n = 0;
      else if ($urandom_range(0, 9) == 0) n = $urandom_range(17, 40);
      else n = $urandom_range(0, 16);
      if (n == 0) addr = 16'($urandom_range(0, 65535));
      else if ($urandom_range(0, 5) == 0) addr = 16'(65536 - n);
      else addr = 16'($urandom_range(0, 65536 - n));
      repeat (n) bytes.push_back(8'($urandom_range(0, 255)));
      build_record(is_s9 ? CHAR_NINE : CHAR_ONE, addr, bytes, 8'h00,
                   $urandom_range(0, 1) == 1, -1);
      send_line(($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0, 1'b1);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Edge records: empty S1, byte at the top address, extreme data values
   // and every hex letter in mixed case, trailing text, S9 at both ends.
   task automatic test_directed_records();
      logic [7:0] bytes[$];
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      build_record(CHAR_ONE, 16'h0000, bytes, 8'h00, 1'b0, -1);
      send_line(0, 1'b1);
      bytes = '{8'hFF};
      build_record(CHAR_ONE, 16'hFFFF, bytes, 8'h00, 1'b0, -1);
      send_line(0, 1'b1);
      bytes = '{8'h00, 8'hFF, 8'hAB, 8'hCD, 8'hEF, 8'h5A};
      build_record(CHAR_ONE, 16'h0000, bytes, 8'h00, 1'b1, -1);
      send_line(3, 1'b1);
      bytes.delete();
      build_record(CHAR_NINE, 16'hFFFF, bytes, 8'h00, 1'b1, -1);
      send_line(0, 1'b1);
      build_record(CHAR_NINE, 16'h0000, bytes, 8'h00, 1'b0, -1);
      send_line(1, 1'b1);
   endtask

   // Random well-formed records; about one in four is sent without sender gaps, and as many without receiver stalls
   task automatic test_random_records();
      int target;
      target = req_total + RANDOM_REQUESTS;
      while (req_total < target) begin
         sender_gaps     = ($urandom_range(0, 3) != 0);
         receiver_stalls = ($urandom_range(0, 3) != 0);
         send_random_record();
      end
   endtask

   // A long record streamed while the receiver holds off, so the block's
   // registers fill and req ready drops.
   task automatic test_backpressure();
      logic [7:0]  bytes[$];
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      repeat (HOLD_BYTES) bytes.push_back(8'($urandom_range(0, 255)));
      hold_request = 1'b1;
      build_record(CHAR_ONE, 16'($urandom_range(0, 65536 - HOLD_BYTES)), bytes, 8'h00,
                   1'b1, -1);
      send_line(0, 1'b1);
   endtask

   // Last stretch: no gaps on either side
   task automatic test_steady_stream();
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      repeat (4) send_random_record();
   endtask

   // One broken line closes the run, followed by noise that must be dropped
   task automatic test_closing_break();
      logic [7:0]  bytes[$];
      logic [7:0]  c;
      int          n;
      int          keep;
      int          pos;
      closing_break = break_kind_type'($urandom_range(0, int'(BREAK_CHECKSUM)));
      // at least two bytes so the overflow record really runs past 0xFFFF
      n = $urandom_range(2, 4);
      repeat (n) bytes.push_back(8'($urandom_range(0, 255)));
      case (closing_break)
         BREAK_LEAD: begin
            do c = 8'($urandom_range(0, 255)); while (c == CHAR_S);
            line_text.delete();
            push_char(c);
            push_char(CHAR_ONE);
            send_line(0, 1'b1);
         end
         BREAK_EMPTY: begin
            line_text.delete();
            send_line(0, 1'b1);
         end
         BREAK_TYPE: begin
            do c = 8'($urandom_range(0, 255)); while (c == CHAR_ONE || c == CHAR_NINE);
            build_record(c, 16'($urandom_range(0, 1000)), bytes, 8'h00, 1'b1, -1);
            send_line(0, 1'b1);
         end
         BREAK_SHORT_COUNT: begin
            bytes.delete();
            build_record(CHAR_ONE, 16'($urandom_range(0, 65535)), bytes, 8'h00, 1'b0,
                         $urandom_range(0, 2));
            send_line(0, 1'b1);
         end
         BREAK_S9_DATA: begin
            build_record(CHAR_NINE, 16'($urandom_range(0, 65535)), bytes, 8'h00, 1'b1, -1);
            send_line(0, 1'b1);
         end
         BREAK_BAD_DIGIT: begin
            build_record(CHAR_ONE, 16'($urandom_range(0, 1000)), bytes, 8'h00, 1'b1, -1);
            pos = $urandom_range(2, line_text.size() - 1);
            do c = 8'($urandom_range(0, 255)); while (hex_value(c) >= 0);
            line_text[pos].ch = c;
            send_line(0, 1'b1);
         end
         BREAK_MISSING_DIGIT: begin
            build_record(CHAR_ONE, 16'($urandom_range(0, 1000)), bytes, 8'h00, 1'b1, -1);
            keep = $urandom_range(2, line_text.size() - 1);
            while (line_text.size() > keep) void'(line_text.pop_back());
            send_line(0, 1'b1);
         end
         BREAK_OVERFLOW: begin
            // one byte more than fits below 0x10000
            build_record(CHAR_ONE, 16'(65536 - n + 1), bytes, 8'h00, 1'b1, -1);
            send_line(0, 1'b1);
         end
         default: begin
            build_record(CHAR_ONE, 16'($urandom_range(0, 1000)), bytes,
                         8'($urandom_range(1, 255)), 1'b1, -1);
            send_line(0, 1'b1);
         end
      endcase
      // Halted from here on: random characters and line marks, no outputs
      repeat (40) begin
         send_request('{ch: 8'($urandom_range(0, 255)),
                        line_end: ($urandom_range(0, 4) == 0)});
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      reset            <= 1'b1;
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      hold_request    = 1'b0;
      req_total   = 0;
      rsp_total   = 0;
      write_total = 0;
      start_total = 0;
      mismatches  = 0;
      reset_parser();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed_records();
      test_random_records();
      test_backpressure();
      test_steady_stream();
      test_closing_break();
      req_chan.valid <= 1'b0;

      // Drain; a response that never comes is left to the watchdog
      while (predicted_outputs.size() != 0) @(posedge clock);
      repeat (LATENCY_SLACK) @(posedge clock);

      $display("Run covered %0d requests and %0d outputs: %0d writes, %0d start addresses,",
               req_total, rsp_total, write_total, start_total);
      $display("a %0d-cycle receiver hold-off, and a closing %s followed by ignored input.",
               HOLD_CYCLES, closing_break.name());
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[srecord_stream_loader_unit.f]
design/srl_pkg.sv
design/srl_stream_if.sv
design/srl_hex_decode.sv
design/srl_parser.sv
design/srecord_stream_loader_unit.sv
sim/srecord_stream_loader_unit_tb.sv
